[src/cst_pkg.sv]
// Shared types, character codes and helper functions of the character stream tokenizer.
`timescale 1ns / 1ps

package cst_pkg;

  // Payload widths of the result fields
  localparam int KIND_W     = 4;
  localparam int CODE_W     = 8;
  localparam int NUM_W      = 31;
  localparam int FRAC_W     = 30;
  localparam int FDIG_W     = 4;
  localparam int LINE_W     = 16;
  localparam int WLEN_W     = 6;
  localparam int OUT_DATA_W = 96;

  // Character codes
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Limits
  localparam logic [NUM_W-1:0]  NUM_SAT   = 31'h7FFF_FFFF;
  localparam logic [FDIG_W-1:0] FRAC_KEEP = 4'd9;
  localparam logic [LINE_W-1:0] LINE_MAX  = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_OP   = 3'd1,
    MODE_INT  = 3'd2,
    MODE_FRAC = 3'd3,
    MODE_WORD = 3'd4
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SINGLE   = 4'd0,
    KIND_AND      = 4'd1,
    KIND_OR       = 4'd2,
    KIND_EQ       = 4'd3,
    KIND_NE       = 4'd4,
    KIND_LE       = 4'd5,
    KIND_GE       = 4'd6,
    KIND_INTEGER  = 4'd7,
    KIND_REAL     = 4'd8,
    KIND_IDENT    = 4'd9,
    KIND_KW_INT   = 4'd10,
    KIND_KW_FLOAT = 4'd11,
    KIND_KW_CHAR  = 4'd12
  } kind_e;

  typedef enum logic [1:0] {
    KW_INT   = 2'd0,
    KW_FLOAT = 2'd1,
    KW_CHAR  = 2'd2
  } kw_e;

  // What the held character does to the token in progress
  typedef enum logic [1:0] {
    ACT_CONT  = 2'd0,  // extends the token, or completes an operator pair
    ACT_END   = 2'd1,  // ends the token, then is lexed fresh
    ACT_FRESH = 2'd2   // nothing in progress, lex fresh
  } act_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_PROC  = 2'd1,
    S_RUN   = 2'd2,
    S_FRESH = 2'd3
  } state_e;

  typedef struct packed {
    logic load;       // take the input transaction into the hold register
    logic clear;      // end marker: return to reset values
    logic cont;       // extend the token in progress
    logic emit_tok;   // send the finished operator, number or keyword
    logic run_start;  // read the first identifier character
    logic run_next;   // send one identifier character, read the next
    logic fresh;      // lex the held character from scratch
  } cmd_t;

  typedef struct packed {
    logic hold_eoi;
    act_e act;
    logic word_run;
    logic fresh_emits;
    logic run_last;
    logic out_free;
  } sts_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic kind_e op_kind(logic [7:0] c);
    kind_e k;
    case (c)
      CH_AMP:  k = KIND_AND;
      CH_BAR:  k = KIND_OR;
      CH_EQ:   k = KIND_EQ;
      CH_BANG: k = KIND_NE;
      CH_LT:   k = KIND_LE;
      CH_GT:   k = KIND_GE;
      default: k = KIND_SINGLE;
    endcase
    return k;
  endfunction

  // True when character c at position pos is consistent with keyword kw
  function automatic logic kw_hit(kw_e kw, logic [WLEN_W-1:0] pos, logic [7:0] c);
    logic [7:0] b;
    logic [WLEN_W-1:0] len;
    b = 8'h00;
    case (kw)
      KW_INT: begin
        len = 6'd3;
        case (pos[2:0])
          3'd0:    b = "i";
          3'd1:    b = "n";
          3'd2:    b = "t";
          default: b = 8'h00;
        endcase
      end
      KW_FLOAT: begin
        len = 6'd5;
        case (pos[2:0])
          3'd0:    b = "f";
          3'd1:    b = "l";
          3'd2:    b = "o";
          3'd3:    b = "a";
          3'd4:    b = "t";
          default: b = 8'h00;
        endcase
      end
      KW_CHAR: begin
        len = 6'd4;
        case (pos[2:0])
          3'd0:    b = "c";
          3'd1:    b = "h";
          3'd2:    b = "a";
          3'd3:    b = "r";
          default: b = 8'h00;
        endcase
      end
      default: len = 6'd0;
    endcase
    return (pos >= len) || (c == b);
  endfunction

endpackage

[src/cst_ctrl.sv]
// Controller state machine of the character stream tokenizer.
`timescale 1ns / 1ps

module cst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  cst_pkg::sts_t sts_i,
  output cst_pkg::cmd_t cmd_o
);

  cst_pkg::state_e state_q, state_d;
  logic done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs: commands for the datapath and input ready
  always_comb begin
    cmd_o      = '0;
    done       = 1'b0;
    s_tready_o = 1'b0;
    case (state_q)
      cst_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      cst_pkg::S_PROC: begin
        if (sts_i.out_free) begin
          if (sts_i.hold_eoi) begin
            cmd_o.clear = 1'b1;
            done        = 1'b1;
          end else begin
            case (sts_i.act)
              cst_pkg::ACT_CONT: begin
                cmd_o.cont = 1'b1;
                done       = 1'b1;
              end
              cst_pkg::ACT_END: begin
                if (sts_i.word_run) begin
                  cmd_o.run_start = 1'b1;
                end else begin
                  cmd_o.emit_tok = 1'b1;
                  if (!sts_i.fresh_emits) begin
                    cmd_o.fresh = 1'b1;
                    done        = 1'b1;
                  end
                end
              end
              default: begin
                cmd_o.fresh = 1'b1;
                done        = 1'b1;
              end
            endcase
          end
        end
      end
      cst_pkg::S_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.run_next = 1'b1;
          if (sts_i.run_last && !sts_i.fresh_emits) begin
            cmd_o.fresh = 1'b1;
            done        = 1'b1;
          end
        end
      end
      cst_pkg::S_FRESH: begin
        if (sts_i.out_free) begin
          cmd_o.fresh = 1'b1;
          done        = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
    // Take the next transaction in the cycle the held one finishes
    if (state_q != cst_pkg::S_IDLE) begin
      s_tready_o = done;
      cmd_o.load = done && s_tvalid_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cst_pkg::S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = cst_pkg::S_PROC;
        end
      end
      cst_pkg::S_PROC: begin
        if (done) begin
          state_d = s_tvalid_i ? cst_pkg::S_PROC : cst_pkg::S_IDLE;
        end else if (sts_i.out_free && !sts_i.hold_eoi && (sts_i.act == cst_pkg::ACT_END)) begin
          state_d = sts_i.word_run ? cst_pkg::S_RUN : cst_pkg::S_FRESH;
        end
      end
      cst_pkg::S_RUN: begin
        if (done) begin
          state_d = s_tvalid_i ? cst_pkg::S_PROC : cst_pkg::S_IDLE;
        end else if (sts_i.out_free && sts_i.run_last) begin
          state_d = cst_pkg::S_FRESH;
        end
      end
      cst_pkg::S_FRESH: begin
        if (done) begin
          state_d = s_tvalid_i ? cst_pkg::S_PROC : cst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[src/cst_dp.sv]
// Datapath of the character stream tokenizer: lexer state, word buffer and result register.
`timescale 1ns / 1ps

module cst_dp #(
  parameter int MAX_WORD = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cst_pkg::cmd_t                  cmd_i,
  output cst_pkg::sts_t                  sts_o,
  input  logic [7:0]                     s_tdata_i,
  input  logic                           s_tlast_i,
  input  logic                           m_tready_i,
  output logic                           m_tvalid_o,
  output logic [cst_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic [cst_pkg::KIND_W-1:0]     m_tuser_o,
  output logic                           m_tlast_o
);

  localparam int AW = $clog2(MAX_WORD);
  localparam int CW = $clog2(MAX_WORD + 1);

  // Held input transaction
  logic [7:0] hold_ch_q;
  logic       hold_eoi_q;

  // Lexer state
  cst_pkg::mode_e                 mode_q, mode_d;
  logic [7:0]                     pend_q, pend_d;
  logic [cst_pkg::NUM_W-1:0]      int_q, int_d;
  logic [cst_pkg::FRAC_W-1:0]     frac_q, frac_d;
  logic [cst_pkg::FDIG_W-1:0]     fcnt_q, fcnt_d;
  logic [CW-1:0]                  wcnt_q, wcnt_d;
  logic                           kw_int_q, kw_int_d;
  logic                           kw_float_q, kw_float_d;
  logic                           kw_char_q, kw_char_d;
  logic [cst_pkg::LINE_W-1:0]     line_q, line_d;
  logic [AW-1:0]                  idx_q, idx_d;

  // Word buffer
  logic [7:0]    mem [MAX_WORD];
  logic [7:0]    rd_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // Result register
  logic                        out_valid_q, out_valid_d;
  logic                        load_out;
  cst_pkg::kind_e              out_kind_q, out_kind_d;
  logic [7:0]                  out_code_q, out_code_d;
  logic [cst_pkg::NUM_W-1:0]   out_num_q, out_num_d;
  logic [cst_pkg::FRAC_W-1:0]  out_frac_q, out_frac_d;
  logic [cst_pkg::FDIG_W-1:0]  out_fdig_q, out_fdig_d;
  logic [cst_pkg::LINE_W-1:0]  out_line_q, out_line_d;
  logic [cst_pkg::WLEN_W-1:0]  out_wlen_q, out_wlen_d;
  logic                        out_last_q, out_last_d;

  // Character classes of the held byte
  logic [7:0]  c;
  logic [7:0]  dsub;
  logic [3:0]  dval;
  logic        c_digit, c_alpha, c_op, c_blank, c_nl;
  logic [7:0]  want;
  logic        hit_int, hit_float, hit_char;
  logic        run_last;
  cst_pkg::act_e act;
  logic [cst_pkg::NUM_W+3:0] int_x10;
  logic [cst_pkg::FRAC_W+3:0] frac_x10;

  assign c       = hold_ch_q;
  assign dsub    = c - cst_pkg::CH_ZERO;
  assign dval    = dsub[3:0];
  assign c_digit = cst_pkg::is_digit(c);
  assign c_alpha = cst_pkg::is_alpha(c);
  assign c_op    = (cst_pkg::op_kind(c) != cst_pkg::KIND_SINGLE);
  assign c_blank = (c == cst_pkg::CH_SPACE) || (c == cst_pkg::CH_TAB);
  assign c_nl    = (c == cst_pkg::CH_NL);
  assign want    = ((pend_q == cst_pkg::CH_AMP) || (pend_q == cst_pkg::CH_BAR)) ?
                   pend_q : cst_pkg::CH_EQ;

  assign hit_int   = (wcnt_q == CW'(3)) && kw_int_q;
  assign hit_float = (wcnt_q == CW'(5)) && kw_float_q;
  assign hit_char  = (wcnt_q == CW'(4)) && kw_char_q;
  assign run_last  = ((CW'(idx_q) + CW'(1)) == wcnt_q);

  assign int_x10  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) +
                    {{cst_pkg::NUM_W{1'b0}}, dval};
  assign frac_x10 = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1) +
                    {{cst_pkg::FRAC_W{1'b0}}, dval};

  always_comb begin
    case (mode_q)
      cst_pkg::MODE_OP:   act = (c == want) ? cst_pkg::ACT_CONT : cst_pkg::ACT_END;
      cst_pkg::MODE_INT:  act = (c_digit || (c == cst_pkg::CH_DOT)) ?
                                cst_pkg::ACT_CONT : cst_pkg::ACT_END;
      cst_pkg::MODE_FRAC: act = c_digit ? cst_pkg::ACT_CONT : cst_pkg::ACT_END;
      cst_pkg::MODE_WORD: act = (c_digit || c_alpha) ? cst_pkg::ACT_CONT : cst_pkg::ACT_END;
      default:            act = cst_pkg::ACT_FRESH;
    endcase
  end

  assign sts_o.hold_eoi    = hold_eoi_q;
  assign sts_o.act         = act;
  assign sts_o.word_run    = (mode_q == cst_pkg::MODE_WORD) && !hit_int && !hit_float && !hit_char;
  assign sts_o.fresh_emits = !(c_blank || c_nl || c_op || c_digit || c_alpha);
  assign sts_o.run_last    = run_last;
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

  // State update
  always_comb begin
    mode_d     = mode_q;
    pend_d     = pend_q;
    int_d      = int_q;
    frac_d     = frac_q;
    fcnt_d     = fcnt_q;
    wcnt_d     = wcnt_q;
    kw_int_d   = kw_int_q;
    kw_float_d = kw_float_q;
    kw_char_d  = kw_char_q;
    line_d     = line_q;
    idx_d      = idx_q;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    load_out   = 1'b0;
    out_kind_d = cst_pkg::KIND_SINGLE;
    out_code_d = 8'h00;
    out_num_d  = '0;
    out_frac_d = '0;
    out_fdig_d = '0;
    out_line_d = line_q;
    out_wlen_d = '0;
    out_last_d = 1'b1;

    if (cmd_i.cont) begin
      case (mode_q)
        cst_pkg::MODE_OP: begin
          load_out   = 1'b1;
          out_kind_d = cst_pkg::op_kind(pend_q);
          mode_d     = cst_pkg::MODE_IDLE;
        end
        cst_pkg::MODE_INT: begin
          if (c_digit) begin
            // saturate at the largest 31-bit value
            if (int_x10 > {4'b0, cst_pkg::NUM_SAT}) begin
              int_d = cst_pkg::NUM_SAT;
            end else begin
              int_d = int_x10[cst_pkg::NUM_W-1:0];
            end
          end else begin
            mode_d = cst_pkg::MODE_FRAC;
          end
        end
        cst_pkg::MODE_FRAC: begin
          // digits past the ninth are dropped
          if (fcnt_q < cst_pkg::FRAC_KEEP) begin
            frac_d = frac_x10[cst_pkg::FRAC_W-1:0];
            fcnt_d = fcnt_q + 4'd1;
          end
        end
        cst_pkg::MODE_WORD: begin
          if (wcnt_q < CW'(MAX_WORD)) begin
            wr_en      = 1'b1;
            wr_addr    = wcnt_q[AW-1:0];
            wcnt_d     = wcnt_q + CW'(1);
            kw_int_d   = kw_int_q   && cst_pkg::kw_hit(cst_pkg::KW_INT,   6'(wcnt_q), c);
            kw_float_d = kw_float_q && cst_pkg::kw_hit(cst_pkg::KW_FLOAT, 6'(wcnt_q), c);
            kw_char_d  = kw_char_q  && cst_pkg::kw_hit(cst_pkg::KW_CHAR,  6'(wcnt_q), c);
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end

    if (cmd_i.emit_tok) begin
      load_out = 1'b1;
      case (mode_q)
        cst_pkg::MODE_OP: begin
          out_kind_d = cst_pkg::KIND_SINGLE;
          out_code_d = pend_q;
        end
        cst_pkg::MODE_INT: begin
          out_kind_d = cst_pkg::KIND_INTEGER;
          out_num_d  = int_q;
        end
        cst_pkg::MODE_FRAC: begin
          out_kind_d = cst_pkg::KIND_REAL;
          out_num_d  = int_q;
          out_frac_d = frac_q;
          out_fdig_d = fcnt_q;
        end
        default: begin
          if (hit_int) begin
            out_kind_d = cst_pkg::KIND_KW_INT;
          end else if (hit_float) begin
            out_kind_d = cst_pkg::KIND_KW_FLOAT;
          end else begin
            out_kind_d = cst_pkg::KIND_KW_CHAR;
          end
        end
      endcase
    end

    if (cmd_i.run_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
      idx_d   = '0;
    end

    if (cmd_i.run_next) begin
      load_out   = 1'b1;
      out_kind_d = cst_pkg::KIND_IDENT;
      out_code_d = rd_q;
      out_wlen_d = 6'(wcnt_q);
      out_last_d = run_last;
      if (!run_last) begin
        rd_en   = 1'b1;
        rd_addr = idx_q + AW'(1);
        idx_d   = idx_q + AW'(1);
      end
    end

    if (cmd_i.fresh) begin
      mode_d = cst_pkg::MODE_IDLE;
      if (c_blank) begin
        mode_d = cst_pkg::MODE_IDLE;
      end else if (c_nl) begin
        if (line_q != cst_pkg::LINE_MAX) begin
          line_d = line_q + 16'd1;
        end
      end else if (c_op) begin
        mode_d = cst_pkg::MODE_OP;
        pend_d = c;
      end else if (c_digit) begin
        mode_d = cst_pkg::MODE_INT;
        int_d  = {{(cst_pkg::NUM_W-4){1'b0}}, dval};
        frac_d = '0;
        fcnt_d = '0;
      end else if (c_alpha) begin
        mode_d     = cst_pkg::MODE_WORD;
        wr_en      = 1'b1;
        wr_addr    = '0;
        wcnt_d     = CW'(1);
        kw_int_d   = cst_pkg::kw_hit(cst_pkg::KW_INT,   6'd0, c);
        kw_float_d = cst_pkg::kw_hit(cst_pkg::KW_FLOAT, 6'd0, c);
        kw_char_d  = cst_pkg::kw_hit(cst_pkg::KW_CHAR,  6'd0, c);
      end else begin
        load_out   = 1'b1;
        out_kind_d = cst_pkg::KIND_SINGLE;
        out_code_d = c;
      end
    end

    if (cmd_i.clear) begin
      mode_d = cst_pkg::MODE_IDLE;
      pend_d = 8'h00;
      int_d  = '0;
      frac_d = '0;
      fcnt_d = '0;
      wcnt_d = '0;
      line_d = 16'd1;
    end
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= cst_pkg::MODE_IDLE;
      pend_q      <= 8'h00;
      int_q       <= '0;
      frac_q      <= '0;
      fcnt_q      <= '0;
      wcnt_q      <= '0;
      kw_int_q    <= 1'b0;
      kw_float_q  <= 1'b0;
      kw_char_q   <= 1'b0;
      line_q      <= 16'd1;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      pend_q      <= pend_d;
      int_q       <= int_d;
      frac_q      <= frac_d;
      fcnt_q      <= fcnt_d;
      wcnt_q      <= wcnt_d;
      kw_int_q    <= kw_int_d;
      kw_float_q  <= kw_float_d;
      kw_char_q   <= kw_char_d;
      line_q      <= line_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hold_ch_q  <= s_tdata_i;
      hold_eoi_q <= s_tlast_i;
    end
    if (load_out) begin
      out_kind_q <= out_kind_d;
      out_code_q <= out_code_d;
      out_num_q  <= out_num_d;
      out_frac_q <= out_frac_d;
      out_fdig_q <= out_fdig_d;
      out_line_q <= out_line_d;
      out_wlen_q <= out_wlen_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= c;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {1'b0, out_wlen_q, out_line_q, out_fdig_q, out_frac_q,
                       out_num_q, out_code_q};

endmodule

[src/char_stream_tokenizer.sv]
// Top level of the character stream tokenizer.
//
//  channel   | direction | tdata                                   | tuser      | tlast
//  ----------+-----------+-----------------------------------------+------------+-------------
//  s_axis    | in        | ch                                      | -          | end_of_input
//  m_axis    | out       | char_code .. word_length (see port)     | token_kind | last
//
// Each input byte is held in a register; the next one is taken in the cycle the held one
// completes, so plain text runs at one byte per cycle while the output is free. A byte
// that ends a token and is itself a single-character token is lexed in a further state.
// A non-keyword word is sent one character per cycle, while the output is free, from the
// word buffer (one read port, registered). Every result waits in a one-entry output
// register; m_axis_tready low with a result waiting stalls processing, not its contents.
// Reset clears all lexer state and the line counter to one; the word buffer is not cleared.
`timescale 1ns / 1ps

module char_stream_tokenizer #(
  parameter int MAX_WORD = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // [7:0] ch
  input  logic                           s_axis_tlast_i,   // end_of_input
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] char_code, [38:8] number_value, [68:39] fraction_value,
  // [72:69] fraction_digits, [88:73] line_number, [94:89] word_length, [95] zero
  output logic [cst_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [cst_pkg::KIND_W-1:0]     m_axis_tuser_o,   // [3:0] token_kind
  output logic                           m_axis_tlast_o    // last
);

  cst_pkg::cmd_t cmd;
  cst_pkg::sts_t sts;

  // Controller: sequences each held byte through token end, identifier run and fresh lex
  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: accumulators, word buffer, keyword match flags and the result register
  cst_dp #(
    .MAX_WORD (MAX_WORD)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

[tb/char_stream_tokenizer_checker.sv]
// Checker: predicts the tokens of the character stream tokenizer and compares the output channel.
`timescale 1ns / 1ps

module char_stream_tokenizer_checker #(
  parameter int MAX_WORD = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [7:0]                     s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [cst_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic [cst_pkg::KIND_W-1:0]     m_axis_tuser_i,
  input  logic                           m_axis_tlast_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import cst_pkg::*;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] code;
    logic [NUM_W-1:0]  num;
    logic [FRAC_W-1:0] frac;
    logic [FDIG_W-1:0] fdig;
    logic [LINE_W-1:0] line;
    logic [WLEN_W-1:0] wlen;
    logic              last;
  } token_t;

  mode_e             lex_state;
  logic [7:0]        held_op;
  logic [NUM_W-1:0]  int_acc;
  logic [FRAC_W-1:0] frac_acc;
  logic [FDIG_W-1:0] frac_cnt;
  logic [7:0]        word_buf [MAX_WORD];
  logic [WLEN_W-1:0] word_cnt;
  logic [LINE_W-1:0] line_cnt;
  token_t            expected_tokens [$];
  int                mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 50)
      $display("%0t mismatch %s: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  function automatic logic digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic kind_e pair_kind(logic [7:0] c);
    case (c)
      CH_AMP:  return KIND_AND;
      CH_BAR:  return KIND_OR;
      CH_EQ:   return KIND_EQ;
      CH_BANG: return KIND_NE;
      CH_LT:   return KIND_LE;
      CH_GT:   return KIND_GE;
      default: return KIND_SINGLE;
    endcase
  endfunction

  function automatic logic word_matches(string kw);
    if (word_cnt != WLEN_W'(kw.len())) return 1'b0;
    for (int i = 0; i < kw.len(); i++)
      if (word_buf[i] != kw[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic clear_lexer();
    lex_state = MODE_IDLE;
    held_op   = '0;
    int_acc   = '0;
    frac_acc  = '0;
    frac_cnt  = '0;
    word_cnt  = '0;
    line_cnt  = LINE_W'(1);
  endtask

  task automatic push_token(input kind_e kind, input logic [7:0] code,
                            input logic [NUM_W-1:0] num, input logic [FRAC_W-1:0] frac,
                            input logic [FDIG_W-1:0] fdig, input logic [WLEN_W-1:0] wlen,
                            input logic last);
    token_t t;
    t.kind = kind;
    t.code = code;
    t.num  = num;
    t.frac = frac;
    t.fdig = fdig;
    t.line = line_cnt;
    t.wlen = wlen;
    t.last = last;
    expected_tokens.push_back(t);
  endtask

  // Keywords give one token; any other word gives one token per kept character
  task automatic push_word();
    if (word_matches("int"))
      push_token(KIND_KW_INT, '0, '0, '0, '0, '0, 1'b1);
    else if (word_matches("float"))
      push_token(KIND_KW_FLOAT, '0, '0, '0, '0, '0, 1'b1);
    else if (word_matches("char"))
      push_token(KIND_KW_CHAR, '0, '0, '0, '0, '0, 1'b1);
    else
      for (int i = 0; i < word_cnt; i++)
        push_token(KIND_IDENT, word_buf[i], '0, '0, '0, word_cnt, (i + 1) == word_cnt);
  endtask

  task automatic lex_fresh_byte(input logic [7:0] c);
    lex_state = MODE_IDLE;
    if (c == CH_SPACE || c == CH_TAB) begin
    end else if (c == CH_NL) begin
      if (line_cnt < LINE_MAX) line_cnt++;
    end else if (pair_kind(c) != KIND_SINGLE) begin
      lex_state = MODE_OP;
      held_op   = c;
    end else if (digit_byte(c)) begin
      lex_state = MODE_INT;
      int_acc   = NUM_W'(c - CH_ZERO);
      frac_acc  = '0;
      frac_cnt  = '0;
    end else if (letter_byte(c)) begin
      lex_state   = MODE_WORD;
      word_buf[0] = c;
      word_cnt    = WLEN_W'(1);
    end else begin
      push_token(KIND_SINGLE, c, '0, '0, '0, '0, 1'b1);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    logic [7:0]  want;
    logic [63:0] wide;
    if (eoi) begin
      clear_lexer();
    end else begin
      case (lex_state)
        MODE_OP: begin
          want = (held_op == CH_AMP || held_op == CH_BAR) ? held_op : CH_EQ;
          if (c == want) begin
            push_token(pair_kind(held_op), '0, '0, '0, '0, '0, 1'b1);
            lex_state = MODE_IDLE;
          end else begin
            push_token(KIND_SINGLE, held_op, '0, '0, '0, '0, 1'b1);
            lex_fresh_byte(c);
          end
        end
        MODE_INT: begin
          if (digit_byte(c)) begin
            wide    = 64'(int_acc) * 64'd10 + 64'(c - CH_ZERO);
            int_acc = (wide > 64'(NUM_SAT)) ? NUM_SAT : wide[NUM_W-1:0];
          end else if (c == CH_DOT) begin
            lex_state = MODE_FRAC;
          end else begin
            push_token(KIND_INTEGER, '0, int_acc, '0, '0, '0, 1'b1);
            lex_fresh_byte(c);
          end
        end
        MODE_FRAC: begin
          if (digit_byte(c)) begin
            if (frac_cnt < FRAC_KEEP) begin
              frac_acc = frac_acc * FRAC_W'(10) + FRAC_W'(c - CH_ZERO);
              frac_cnt++;
            end
          end else begin
            push_token(KIND_REAL, '0, int_acc, frac_acc, frac_cnt, '0, 1'b1);
            lex_fresh_byte(c);
          end
        end
        MODE_WORD: begin
          if (digit_byte(c) || letter_byte(c)) begin
            if (word_cnt < MAX_WORD) begin
              word_buf[word_cnt] = c;
              word_cnt++;
            end
          end else begin
            push_word();
            lex_fresh_byte(c);
          end
        end
        default: lex_fresh_byte(c);
      endcase
    end
  endtask

  task automatic check_token();
    token_t                 want;
    logic [OUT_DATA_W-1:0]  d;
    d = m_axis_tdata_i;
    if (expected_tokens.size() == 0) begin
      report_mismatch("token with none expected, token_kind", 64'(m_axis_tuser_i), 64'd0);
    end else begin
      want = expected_tokens.pop_front();
      if (m_axis_tuser_i != want.kind)
        report_mismatch("token_kind", 64'(m_axis_tuser_i), 64'(want.kind));
      if (d[7:0] != want.code)   report_mismatch("char_code", 64'(d[7:0]), 64'(want.code));
      if (d[38:8] != want.num)   report_mismatch("number_value", 64'(d[38:8]), 64'(want.num));
      if (d[68:39] != want.frac)
        report_mismatch("fraction_value", 64'(d[68:39]), 64'(want.frac));
      if (d[72:69] != want.fdig)
        report_mismatch("fraction_digits", 64'(d[72:69]), 64'(want.fdig));
      if (d[88:73] != want.line) report_mismatch("line_number", 64'(d[88:73]), 64'(want.line));
      if (d[94:89] != want.wlen) report_mismatch("word_length", 64'(d[94:89]), 64'(want.wlen));
      if (d[95] != 1'b0)         report_mismatch("tdata pad bit", 64'(d[95]), 64'd0);
      if (m_axis_tlast_i != want.last)
        report_mismatch("last", 64'(m_axis_tlast_i), 64'(want.last));
    end
  endtask

  // Compare before predicting: a result never stems from the byte taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_lexer();
      expected_tokens.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_token();
      if (s_axis_tvalid_i && s_axis_tready_i) lex_byte(s_axis_tdata_i, s_axis_tlast_i);
      pending_o <= expected_tokens.size();
    end
  end

endmodule

[tb/tb_char_stream_tokenizer.sv]
// Testbench top: drives text bytes into the tokenizer, throttles its output and gives the verdict.
`timescale 1ns / 1ps

module tb_char_stream_tokenizer;
  import cst_pkg::*;

  localparam int MAX_WORD        = 32;
  // Quiet cycles tolerated; far above the longest gap or stall streak at 73 percent
  localparam int IDLE_LIMIT      = 4000;
  // Longest identifier run (MAX_WORD characters after the first buffer read) with margin
  localparam int SETTLE_CYCLES   = 48;
  localparam int ITEMS_PER_PHASE = 21;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  int fail_count;
  int pending_tokens;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_items     = 0;

  // Idle percentages per phase: none, sender idle, receiver stalling, both
  int phase_send_pct [4] = '{0, 73, 0, 15};
  int phase_recv_pct [4] = '{0, 0, 73, 15};

  string keyword_like [7] = '{"int", "float", "char", "in", "chars", "Float", "cha"};
  string op_chars         = "&|=!<>";
  string punct_chars      = "(){};,+-*/#";
  string blank_chars      = " \t\n";

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  char_stream_tokenizer #(
    .MAX_WORD(MAX_WORD)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  char_stream_tokenizer_checker #(
    .MAX_WORD(MAX_WORD)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .m_axis_tlast_i (m_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending_tokens)
  );

  // Stall the receiver at random on every falling edge
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort when no transaction completes on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL char_stream_tokenizer");
    $finish;
  end

  // Present one byte at a falling edge, after a random gap, and hold it until accepted
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom);
      s_tlast  = 1'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tlast  = eoi;
    do @(posedge clk); while (!s_tready);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Drop valid and hold off until every predicted token has come out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_tokens != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(9));
  endfunction

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_byte(rand_digit(), 1'b0);
  endtask

  // Emit one random lexeme; mostly well formed, some noise and end markers
  task automatic send_lexeme();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // mostly short words, now and then one near or past the word buffer size
      n = ($urandom_range(11) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      send_byte(rand_letter(), 1'b0);
      for (int i = 1; i < n; i++)
        send_byte(($urandom_range(2) == 0) ? rand_digit() : rand_letter(), 1'b0);
    end else if (pick < 30) begin
      send_text(keyword_like[$urandom_range(6)]);
    end else if (pick < 44) begin
      // long digit strings can drive the value into saturation
      send_digits(($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4));
    end else if (pick < 54) begin
      send_digits($urandom_range(1, 3));
      send_byte(CH_DOT, 1'b0);
      send_digits(($urandom_range(7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4));
    end else if (pick < 69) begin
      c = op_chars[$urandom_range(5)];
      send_byte(c, 1'b0);
      case ($urandom_range(3))
        0, 1: send_byte((c == CH_AMP || c == CH_BAR) ? c : CH_EQ, 1'b0);
        2:    send_byte(op_chars[$urandom_range(5)], 1'b0);
        default: ;
      endcase
    end else if (pick < 80) begin
      send_byte(blank_chars[$urandom_range(2)], 1'b0);
    end else if (pick < 91) begin
      send_byte(punct_chars[$urandom_range(10)], 1'b0);
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    int mark;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every pair operator, the int keyword, real ended by newline, word ended by an
    // operator start, broken pair, extreme bytes, then a word dropped by the end marker
    send_text("&&||==!=<=>=");
    send_text("int 7.25\n");
    send_text("ab=9");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("q");
    send_byte(8'($urandom_range(255)), 1'b1);

    // Advance the line counter, show it on a token, then reset by end marker
    repeat (3) send_byte(CH_NL, 1'b0);
    send_text("z;");
    send_byte(8'($urandom_range(255)), 1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send_pct[p];
      recv_stall_pct = phase_recv_pct[p];
      mark = sent_items;
      while (sent_items - mark < ITEMS_PER_PHASE) send_lexeme();
      // flush any token in progress so it is checked inside this phase
      send_byte(CH_SPACE, 1'b0);
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("PASS char_stream_tokenizer");
    else
      $display("FAIL char_stream_tokenizer");
    $finish;
  end

endmodule
